[hw/rtl/pc_pkg.sv]
package pc_pkg;

  // Width of the correlation result and of the root search.
  localparam int CorrBits = 16;
  localparam logic [CorrBits-1:0] CorrMax = 16'h7fff;

  // The squared covariance is compared against q^2 * Va * Vb with q in Q1.15,
  // so both sides carry a factor of 2^30.
  localparam int RootShift = 30;

  localparam int StepBits = 4;
  localparam logic [StepBits-1:0] StepFirst = StepBits'(CorrBits - 1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_DONE
  } pc_state_e;

  // Products formed one after another by the shared multiplier.
  typedef enum logic [2:0] {
    OP_NSAA,
    OP_SASA,
    OP_NSBB,
    OP_SBSB,
    OP_NSAB,
    OP_SASB,
    OP_VAVB,
    OP_CMCM
  } pc_op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_DROP = 2'd2
  } pc_status_e;

  typedef struct packed {
    logic   accept_en;
    logic   clear_acc;
    logic   mul_start;
    logic   mul_capture;
    pc_op_e op;
    logic   root_init;
    logic   root_step;
    logic   load_out;
  } pc_cmd_t;

  typedef struct packed {
    logic acc_last;
    logic mul_busy;
    logic out_busy;
  } pc_stat_t;

endpackage

[hw/rtl/pc_mul.sv]
module pc_mul #(
  parameter int WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [WIDTH-1:0]   x_i,
  input  logic [WIDTH-1:0]   y_i,
  output logic               busy_o,
  output logic [2*WIDTH-1:0] prod_o
);

  localparam int CntW = $clog2(WIDTH + 1);

  logic [CntW-1:0]    cnt_q;
  logic [2*WIDTH-1:0] acc_q;
  logic [2*WIDTH-1:0] mc_q;
  logic [WIDTH-1:0]   mp_q;

  assign busy_o = (cnt_q != '0);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(WIDTH);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // One multiplier bit per cycle, least significant first.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= (2*WIDTH)'(x_i);
      mp_q  <= y_i;
    end else if (busy_o) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

endmodule

[hw/rtl/pc_dp.sv]
module pc_dp #(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_a_i,
  input  logic signed [15:0] sample_b_i,
  input  logic               vectors_valid_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] correlation_o,
  output logic [1:0]         status_o,
  input  pc_pkg::pc_cmd_t    cmd_i,
  output pc_pkg::pc_stat_t   stat_o
);

  localparam int XW = (SAMPLE_BITS <= 16) ? SAMPLE_BITS : 17;
  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int SW = XW + CW;
  localparam int QW = 2 * XW - 1 + CW;
  localparam int PW = 2 * XW + CW;
  localparam int VW = QW + CW;
  localparam int NW = CW + PW;
  localparam int MW = NW + 1;
  localparam int DW = 2 * VW;
  localparam int RW = 2 * MW;
  localparam int EW = RW + 33;
  localparam int QB = pc_pkg::CorrBits;

  logic accept;
  logic signed [XW-1:0] a_x, b_x;

  if (SAMPLE_BITS <= 16) begin : g_sext
    assign a_x = sample_a_i[SAMPLE_BITS-1:0];
    assign b_x = sample_b_i[SAMPLE_BITS-1:0];
  end else begin : g_zext
    assign a_x = {1'b0, sample_a_i};
    assign b_x = {1'b0, sample_b_i};
  end

  // Input register and product stage.
  logic                  vld1_q, vld2_q;
  logic                  v1_q, l1_q, v2_q, l2_q;
  logic signed [XW-1:0]  a1_q, b1_q, a2_q, b2_q;
  logic signed [2*XW-1:0] sq_a, sq_b, pr_ab;
  logic [2*XW-2:0]       aa2_q, bb2_q;
  logic signed [2*XW-1:0] ab2_q;

  assign in_stall_o = !cmd_i.accept_en || (vld1_q && l1_q) || (vld2_q && l2_q);
  assign accept     = in_valid_i && !in_stall_o;

  assign sq_a  = a1_q * a1_q;
  assign sq_b  = b1_q * b1_q;
  assign pr_ab = a1_q * b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= accept;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a1_q <= a_x;
      b1_q <= b_x;
      v1_q <= vectors_valid_i;
      l1_q <= last_pair_i;
    end
    aa2_q <= sq_a[2*XW-2:0];
    bb2_q <= sq_b[2*XW-2:0];
    ab2_q <= pr_ab;
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    v2_q  <= v1_q;
    l2_q  <= l1_q;
  end

  // Run accumulators.
  logic [CW-1:0]        cnt_q;
  logic signed [SW-1:0] sa_q, sb_q;
  logic [QW-1:0]        saa_q, sbb_q;
  logic signed [PW-1:0] sab_q;
  logic                 all_valid_q, dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      saa_q       <= '0;
      sbb_q       <= '0;
      sab_q       <= '0;
      all_valid_q <= 1'b1;
      dropped_q   <= 1'b0;
    end else if (cmd_i.clear_acc) begin
      cnt_q       <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      saa_q       <= '0;
      sbb_q       <= '0;
      sab_q       <= '0;
      all_valid_q <= 1'b1;
      dropped_q   <= 1'b0;
    end else if (vld2_q) begin
      if (!v2_q) begin
        all_valid_q <= 1'b0;
      end
      if (cnt_q < CW'(MAX_PAIRS)) begin
        cnt_q <= cnt_q + CW'(1);
        sa_q  <= sa_q + SW'(a2_q);
        sb_q  <= sb_q + SW'(b2_q);
        saa_q <= saa_q + QW'(aa2_q);
        sbb_q <= sbb_q + QW'(bb2_q);
        sab_q <= sab_q + PW'(ab2_q);
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  // Magnitudes and signs of the sums.
  logic [SW-1:0] sa_mag, sb_mag;
  logic [PW-1:0] sab_mag;
  logic          neg_a, neg_b;

  assign sa_mag  = sa_q[SW-1] ? SW'(-sa_q) : SW'(sa_q);
  assign sb_mag  = sb_q[SW-1] ? SW'(-sb_q) : SW'(sb_q);
  assign sab_mag = sab_q[PW-1] ? PW'(-sab_q) : PW'(sab_q);
  assign neg_a   = sab_q[PW-1];
  assign neg_b   = sa_q[SW-1] ^ sb_q[SW-1];

  // Product registers filled by the shared multiplier.
  logic [VW-1:0] p_nsaa_q, p_sasa_q, p_nsbb_q, p_sbsb_q;
  logic [NW-1:0] p_nsab_q, p_sasb_q;
  logic [DW-1:0] d_q;
  logic [RW-1:0] r_q;
  logic [VW-1:0] va, vb;
  logic [MW-1:0] cm;
  logic          neg;

  assign va = p_nsaa_q - p_sasa_q;
  assign vb = p_nsbb_q - p_sbsb_q;

  // Covariance term n*Sab - Sa*Sb as sign and magnitude.
  always_comb begin
    priority if (neg_a != neg_b) begin
      cm  = MW'(p_nsab_q) + MW'(p_sasb_q);
      neg = neg_a;
    end else if (p_nsab_q >= p_sasb_q) begin
      cm  = MW'(p_nsab_q - p_sasb_q);
      neg = neg_a;
    end else begin
      cm  = MW'(p_sasb_q - p_nsab_q);
      neg = !neg_a;
    end
  end

  logic [MW-1:0]   mul_x, mul_y;
  logic [2*MW-1:0] prod;
  logic            mul_busy;

  always_comb begin
    unique case (cmd_i.op)
      pc_pkg::OP_NSAA: begin mul_x = MW'(cnt_q);  mul_y = MW'(saa_q);   end
      pc_pkg::OP_SASA: begin mul_x = MW'(sa_mag); mul_y = MW'(sa_mag);  end
      pc_pkg::OP_NSBB: begin mul_x = MW'(cnt_q);  mul_y = MW'(sbb_q);   end
      pc_pkg::OP_SBSB: begin mul_x = MW'(sb_mag); mul_y = MW'(sb_mag);  end
      pc_pkg::OP_NSAB: begin mul_x = MW'(cnt_q);  mul_y = MW'(sab_mag); end
      pc_pkg::OP_SASB: begin mul_x = MW'(sa_mag); mul_y = MW'(sb_mag);  end
      pc_pkg::OP_VAVB: begin mul_x = MW'(va);     mul_y = MW'(vb);      end
      pc_pkg::OP_CMCM: begin mul_x = cm;          mul_y = cm;           end
    endcase
  end

  pc_mul #(
    .WIDTH(MW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_start),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .busy_o (mul_busy),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_capture) begin
      unique case (cmd_i.op)
        pc_pkg::OP_NSAA: p_nsaa_q <= prod[VW-1:0];
        pc_pkg::OP_SASA: p_sasa_q <= prod[VW-1:0];
        pc_pkg::OP_NSBB: p_nsbb_q <= prod[VW-1:0];
        pc_pkg::OP_SBSB: p_sbsb_q <= prod[VW-1:0];
        pc_pkg::OP_NSAB: p_nsab_q <= prod[NW-1:0];
        pc_pkg::OP_SASB: p_sasb_q <= prod[NW-1:0];
        pc_pkg::OP_VAVB: d_q      <= prod[DW-1:0];
        pc_pkg::OP_CMCM: r_q      <= prod[RW-1:0];
      endcase
    end
  end

  // Bit-serial search for the largest q with q^2 * D <= C^2 * 2^30.
  // re holds the remaining margin, ra = q * D * 2^(k+1), rb = D * 4^k.
  logic [EW-1:0] re_q, ra_q, rb_q, t_sum;
  logic [QB-1:0] q_q;
  logic          fit;

  assign t_sum = ra_q + rb_q;
  assign fit   = (t_sum <= re_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_init) begin
      re_q <= EW'(r_q) << pc_pkg::RootShift;
      ra_q <= '0;
      rb_q <= EW'(d_q) << pc_pkg::RootShift;
      q_q  <= '0;
    end else if (cmd_i.root_step) begin
      rb_q <= rb_q >> 2;
      q_q  <= {q_q[QB-2:0], fit};
      if (fit) begin
        re_q <= re_q - t_sum;
        ra_q <= (ra_q >> 1) + rb_q;
      end else begin
        ra_q <= ra_q >> 1;
      end
    end
  end

  // Result and output register.
  logic signed [QB-1:0] corr_d, corr_q;
  pc_pkg::pc_status_e   stat_d, stat_q;
  logic                 out_valid_q;

  always_comb begin
    if (!all_valid_q || (d_q == '0)) begin
      corr_d = '0;
      stat_d = pc_pkg::STAT_ZERO;
    end else begin
      if (neg) begin
        corr_d = QB'(-q_q);
      end else if (q_q > pc_pkg::CorrMax) begin
        corr_d = pc_pkg::CorrMax;
      end else begin
        corr_d = q_q;
      end
      stat_d = dropped_q ? pc_pkg::STAT_DROP : pc_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      corr_q <= corr_d;
      stat_q <= stat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign correlation_o = corr_q;
  assign status_o      = stat_q;

  assign stat_o.acc_last = vld2_q && l2_q;
  assign stat_o.mul_busy = mul_busy;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

endmodule

[hw/rtl/pc_ctrl.sv]
module pc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pc_pkg::pc_stat_t stat_i,
  output pc_pkg::pc_cmd_t  cmd_o
);

  pc_pkg::pc_state_e             state_q, state_d;
  pc_pkg::pc_op_e                op_q, op_d, op_next;
  logic [pc_pkg::StepBits-1:0]   step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pc_pkg::ST_ACCUM;
      op_q    <= pc_pkg::OP_NSAA;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    unique case (op_q)
      pc_pkg::OP_NSAA: op_next = pc_pkg::OP_SASA;
      pc_pkg::OP_SASA: op_next = pc_pkg::OP_NSBB;
      pc_pkg::OP_NSBB: op_next = pc_pkg::OP_SBSB;
      pc_pkg::OP_SBSB: op_next = pc_pkg::OP_NSAB;
      pc_pkg::OP_NSAB: op_next = pc_pkg::OP_SASB;
      pc_pkg::OP_SASB: op_next = pc_pkg::OP_VAVB;
      pc_pkg::OP_VAVB: op_next = pc_pkg::OP_CMCM;
      pc_pkg::OP_CMCM: op_next = pc_pkg::OP_NSAA;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    unique case (state_q)
      pc_pkg::ST_ACCUM: begin
        if (stat_i.acc_last) begin
          state_d = pc_pkg::ST_MUL_GO;
          op_d    = pc_pkg::OP_NSAA;
        end
      end
      pc_pkg::ST_MUL_GO: state_d = pc_pkg::ST_MUL_WAIT;
      pc_pkg::ST_MUL_WAIT: begin
        if (!stat_i.mul_busy) begin
          op_d = op_next;
          if (op_q == pc_pkg::OP_CMCM) begin
            state_d = pc_pkg::ST_ROOT_INIT;
          end else begin
            state_d = pc_pkg::ST_MUL_GO;
          end
        end
      end
      pc_pkg::ST_ROOT_INIT: begin
        state_d = pc_pkg::ST_ROOT;
        step_d  = pc_pkg::StepFirst;
      end
      pc_pkg::ST_ROOT: begin
        step_d = step_q - pc_pkg::StepBits'(1);
        if (step_q == '0) begin
          state_d = pc_pkg::ST_DONE;
        end
      end
      pc_pkg::ST_DONE: begin
        if (!stat_i.out_busy) begin
          state_d = pc_pkg::ST_ACCUM;
        end
      end
      default: state_d = pc_pkg::ST_ACCUM;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o             = '0;
    cmd_o.op          = op_q;
    cmd_o.accept_en   = (state_q == pc_pkg::ST_ACCUM);
    cmd_o.mul_start   = (state_q == pc_pkg::ST_MUL_GO);
    cmd_o.mul_capture = (state_q == pc_pkg::ST_MUL_WAIT) && !stat_i.mul_busy;
    cmd_o.root_init   = (state_q == pc_pkg::ST_ROOT_INIT);
    cmd_o.root_step   = (state_q == pc_pkg::ST_ROOT);
    cmd_o.load_out    = (state_q == pc_pkg::ST_DONE) && !stat_i.out_busy;
    cmd_o.clear_acc   = cmd_o.load_out;
  end

endmodule

[hw/rtl/pearson_correlation.sv]
// Pearson correlation of a run of paired signed samples.
// Input channel: in_valid_i / in_stall_o carry one sample pair per item, with
// vectors_valid_i and last_pair_i. Output channel: out_valid_o / out_stall_i
// carry one item per run: correlation_o in Q1.15 and status_o.
// Pairs of a run are taken one per cycle while in_stall_o is low, into a
// two-stage product pipeline and exact integer sums. A pair past MAX_PAIRS
// is not summed and marks the run as dropped. Once the last pair is taken,
// the input stalls until the result is in the output register.
// The finish runs eight products through one bit-serial multiplier of
// M = 2*S + 2*C + 1 bits (S sample width, C = clog2(MAX_PAIRS+1)), then a
// 16-step root search, one bit per cycle. The result waits in the output
// register while out_stall_i is high, and the next run's pairs are taken
// meanwhile. Reset clears the sums, the control and the output valid; no
// pair or result is pending after reset.
module pearson_correlation #(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_a_i,
  input  logic signed [15:0] sample_b_i,
  input  logic               vectors_valid_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] correlation_o,
  output logic [1:0]         status_o
);

  pc_pkg::pc_cmd_t  cmd;
  pc_pkg::pc_stat_t stat;

  pc_dp #(
    .MAX_PAIRS  (MAX_PAIRS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_a_i     (sample_a_i),
    .sample_b_i     (sample_b_i),
    .vectors_valid_i(vectors_valid_i),
    .last_pair_i    (last_pair_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .correlation_o  (correlation_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

  pc_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .cmd_o (cmd)
  );

`ifndef SYNTHESIS
  a_zero_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pc_pkg::STAT_ZERO) |-> correlation_o == '0)
    else $error("forced-zero result carries a nonzero coefficient");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.accept_en |-> in_stall_o)
    else $error("input taken while the finish is running");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result loaded over a stalled result");

  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |-> !stat.mul_busy)
    else $error("multiplier started while busy");
`endif

endmodule

[sim/testbench.sv]
module testbench;

  localparam int MaxPairs   = 1024;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic signed [15:0] corr;
    pc_pkg::pc_status_e stat;
  } corr_result_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               vv;
    logic               last;
    bit                 typed;
    logic signed [15:0] corr;
    pc_pkg::pc_status_e stat;
  } pair_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] sample_a_i;
  logic signed [15:0] sample_b_i;
  logic               vectors_valid_i;
  logic               last_pair_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] correlation_o;
  logic [1:0]         status_o;

  pearson_correlation i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sample_a_i,
    .sample_b_i,
    .vectors_valid_i,
    .last_pair_i,
    .out_valid_o,
    .out_stall_i,
    .correlation_o,
    .status_o
  );

  // Running sums of the run in progress.
  int            run_count;
  longint        run_sa, run_sb, run_saa, run_sbb, run_sab;
  bit            run_valid, run_dropped;
  corr_result_t  pending_results[$];
  int            fail_count;
  bit            long_hold_req;
  longint        cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_run();
    run_count   = 0;
    run_sa      = 0;
    run_sb      = 0;
    run_saa     = 0;
    run_sbb     = 0;
    run_sab     = 0;
    run_valid   = 1'b1;
    run_dropped = 1'b0;
  endfunction

  // Exact Q1.15 coefficient: the largest q with q^2 * Va * Vb <= C^2 * 2^30.
  function automatic void calc_coefficient(output logic signed [15:0] r, output bit zero);
    longint       n, va, vb, c, cm;
    logic [191:0] den, rhs, lhs;
    int           lo, hi, mid;
    bit           neg;
    n    = run_count;
    va   = n * run_saa - run_sa * run_sa;
    vb   = n * run_sbb - run_sb * run_sb;
    zero = (va <= 0) || (vb <= 0);
    r    = '0;
    if (zero) return;
    c   = n * run_sab - run_sa * run_sb;
    neg = c < 0;
    cm  = neg ? -c : c;
    den = 192'(va) * 192'(vb);
    rhs = (192'(cm) * 192'(cm)) << pc_pkg::RootShift;
    lo  = 0;
    hi  = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 192'(longint'(mid) * mid) * den;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) r = 16'(-lo);
    else r = (lo > 32767) ? pc_pkg::CorrMax : 16'(lo);
  endfunction

  // Updates the sums with one accepted pair; a last pair queues the result.
  function automatic void take_pair(pair_row_t p);
    corr_result_t res;
    bit           zero;
    longint       a, b;
    a = p.a;
    b = p.b;
    if (!p.vv) run_valid = 1'b0;
    if (run_count < MaxPairs) begin
      run_count++;
      run_sa  += a;
      run_sb  += b;
      run_saa += a * a;
      run_sbb += b * b;
      run_sab += a * b;
    end else begin
      run_dropped = 1'b1;
    end
    if (!p.last) return;
    calc_coefficient(res.corr, zero);
    if (!run_valid || zero) begin
      res.corr = '0;
      res.stat = pc_pkg::STAT_ZERO;
    end else if (run_dropped) begin
      res.stat = pc_pkg::STAT_DROP;
    end else begin
      res.stat = pc_pkg::STAT_OK;
    end
    if (p.typed) begin
      if (res.corr !== p.corr || res.stat !== p.stat)
        $display("%0t: directed row disagrees with prediction: typed %0d/%0d, predicted %0d/%0d",
                 $time, p.corr, p.stat, res.corr, res.stat);
      res.corr = p.corr;
      res.stat = p.stat;
    end
    pending_results.push_back(res);
    clear_run();
  endfunction

  bit quiet_send;

  task automatic send_pair(pair_row_t p);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_a_i      <= p.a;
    sample_b_i      <= p.b;
    vectors_valid_i <= p.vv;
    last_pair_i     <= p.last;
    do @(posedge clk_i); while (in_stall_o);
    take_pair(p);
  endtask

  function automatic pair_row_t row(int a, int b, bit vv, bit last, bit typed = 0,
                                    int corr = 0,
                                    pc_pkg::pc_status_e stat = pc_pkg::STAT_OK);
    pair_row_t p;
    p.a     = 16'(a);
    p.b     = 16'(b);
    p.vv    = vv;
    p.last  = last;
    p.typed = typed;
    p.corr  = 16'(corr);
    p.stat  = stat;
    return p;
  endfunction

  // Random run with samples drawn by one of several shapes.
  task automatic send_run(int len, bit noisy);
    pair_row_t p;
    int        shape, k, a, b;
    shape = $urandom_range(0, 4);
    k     = $urandom_range(0, 6) - 3;
    for (int i = 0; i < len; i++) begin
      a = $signed(16'($urandom()));
      case (shape)
        0: b = $signed(16'($urandom()));
        1: b = a * k / 4 + $signed(16'($urandom())) / 64;
        2: b = -a;
        3: begin
          a = $urandom_range(0, 1) ? 32767 : -32768;
          b = $urandom_range(0, 1) ? 32767 : -32768;
        end
        default: begin
          a = $urandom_range(0, 8) - 4;
          b = $urandom_range(0, 1) ? 5 : -5;
        end
      endcase
      if (b > 32767) b = 32767;
      if (b < -32768) b = -32768;
      p = row(a, b, !(noisy && $urandom_range(0, 19) == 0), i == len - 1);
      send_pair(p);
    end
  endtask

  // Receiver: random hold-off per item, one long hold on request.
  initial begin
    int            hold;
    bit            quiet_recv;
    corr_result_t  want;
    out_stall_i = 1'b0;
    hold        = 0;
    quiet_recv  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: corr %0d status %0d",
                   $time, correlation_o, status_o);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (correlation_o !== want.corr) begin
            $display("%0t: correlation expected %0d actual %0d", $time, want.corr,
                     correlation_o);
            fail_count++;
          end
          if (status_o !== want.stat) begin
            $display("%0t: status expected %0d actual %0d", $time, want.stat, status_o);
            fail_count++;
          end
        end
        if ($urandom_range(0, 9) == 0) quiet_recv = !quiet_recv;
        hold = quiet_recv ? 0 : $urandom_range(0, 16);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 3000;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("pearson_correlation verification failed");
        $finish;
      end
    end
  end

  initial begin
    pair_row_t directed[$];
    int        short_items, run_idx;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_a_i      = '0;
    sample_b_i      = '0;
    vectors_valid_i = 1'b0;
    last_pair_i     = 1'b0;
    fail_count      = 0;
    long_hold_req   = 1'b0;
    quiet_send      = 1'b0;
    clear_run();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A run of one pair has no variance.
    directed.push_back(row(100, 200, 1, 1, 1, 0, pc_pkg::STAT_ZERO));
    // Perfect correlation saturates, perfect anticorrelation does not.
    directed.push_back(row(32767, 32767, 1, 0));
    directed.push_back(row(-32768, -32768, 1, 1, 1, 32767, pc_pkg::STAT_OK));
    directed.push_back(row(32767, -32768, 1, 0));
    directed.push_back(row(-32768, 32767, 1, 1, 1, -32768, pc_pkg::STAT_OK));
    // An invalid pair anywhere forces zero.
    directed.push_back(row(5, -7, 0, 0));
    directed.push_back(row(9, 3, 1, 1, 1, 0, pc_pkg::STAT_ZERO));
    // Constant first vector.
    directed.push_back(row(7, 1, 1, 0));
    directed.push_back(row(7, -5, 1, 0));
    directed.push_back(row(7, 300, 1, 1, 1, 0, pc_pkg::STAT_ZERO));
    directed.push_back(row(1000, -2000, 1, 0));
    directed.push_back(row(-300, 4000, 1, 0));
    directed.push_back(row(12345, -1, 1, 0));
    directed.push_back(row(-32768, 32767, 1, 1));
    directed.push_back(row(0, 0, 1, 0));
    directed.push_back(row(1, 1, 1, 0));
    directed.push_back(row(-1, -1, 1, 1, 1, 32767, pc_pkg::STAT_OK));
    directed.push_back(row(10, 20, 1, 0));
    directed.push_back(row(30, -40, 0, 1, 1, 0, pc_pkg::STAT_ZERO));
    directed.push_back(row(-21846, 21845, 1, 0));
    directed.push_back(row(21845, -21846, 1, 1));
    foreach (directed[i]) send_pair(directed[i]);

    // Capacity: a run that fills the sums and then drops three pairs.
    send_run(MaxPairs + 3, 0);

    short_items = 0;
    run_idx     = 0;
    while (short_items < 850) begin
      int len;
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
      if (run_idx == 10) long_hold_req = 1'b1;
      if (run_idx == 40) begin
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 7) == 0) quiet_send = !quiet_send;
      send_run(len, 1);
      short_items += len;
      run_idx++;
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("pearson_correlation verification clean");
    end else begin
      $display("pearson_correlation verification failed");
    end
    $finish;
  end

endmodule
